[hdl/sprt_pkg.sv]
// Package for the spare row remap table: operation and status codes,
// register indexes and the control struct shared by the datapath modules.
// No dependencies.
`default_nettype none

package sprt_pkg;

   // Width of the row fields on the channels.
   localparam int OUT_ROW_W = 11;

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;

   typedef enum logic [1:0] {
      MODE_DISABLE = 2'd0,
      MODE_ENABLE  = 2'd1,
      MODE_CLEAR   = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_DUP   = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BANKS  = 1'd0,
      CSR_SLICES = 1'd1
   } csr_idx_type;

   // Table write controls produced by the update logic.
   typedef struct packed {
      logic wr_en;
      logic clr_all;
   } tbl_ctl_type;

endpackage : sprt_pkg

`default_nettype wire

[hdl/sprt_req_if.sv]
// Request channel of the spare row remap table: valid/ready handshake and
// one command beat. No dependencies.
`default_nettype none

interface sprt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [10:0] row;
   logic [1:0]  bank;
   logic [2:0]  subbank;
   logic        slice;

   modport source (output valid, mode, row, bank, subbank, slice, input ready);
   modport sink   (input valid, mode, row, bank, subbank, slice, output ready);
endinterface : sprt_req_if

`default_nettype wire

[hdl/sprt_rsp_if.sv]
// Response channel of the spare row remap table: valid/ready handshake and
// one status plus entry beat. No dependencies.
`default_nettype none

interface sprt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        first_valid;
   logic [10:0] first_row;
   logic        second_valid;
   logic [10:0] second_row;

   modport source (output valid, status, first_valid, first_row, second_valid,
                   second_row, input ready);
   modport sink   (input valid, status, first_valid, first_row, second_valid,
                   second_row, output ready);
endinterface : sprt_rsp_if

`default_nettype wire

[hdl/sprt_table.sv]
// Entry storage: a memory with a registered read port, per-entry live bits
// cleared at once by reset or clear-all, and a one-deep write bypass.
// Depends on sprt_pkg.
`default_nettype none

module sprt_table
   import sprt_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int ENT_W = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_idx,
   input  wire tbl_ctl_type       ctl,
   input  wire logic [ENT_W-1:0]  wr_data,
   output      logic [ENT_W-1:0]  cur_entry
);

   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [DEPTH-1:0] live_ff;
   logic             byp_valid_ff;
   logic [IDX_W-1:0] byp_idx_ff;
   logic [ENT_W-1:0] byp_data_ff;
   logic             byp_hit;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
         rd_idx_ff  <= rd_idx;
      end
   end

   // The write always targets the entry that was read last.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[rd_idx_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         live_ff <= '0;
      end else if (ctl.wr_en) begin
         live_ff[rd_idx_ff] <= 1'b1;
      end
   end

   // A read issued in the same cycle as a write sees old memory data, so the
   // latest write is kept and replayed when its index matches.
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         byp_valid_ff <= 1'b0;
      end else if (ctl.wr_en) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         byp_idx_ff  <= rd_idx_ff;
         byp_data_ff <= wr_data;
      end
   end

   assign byp_hit = byp_valid_ff && (byp_idx_ff == rd_idx_ff);

   always_comb begin
      if (!live_ff[rd_idx_ff]) begin
         cur_entry = '0;
      end else if (byp_hit) begin
         cur_entry = byp_data_ff;
      end else begin
         cur_entry = rd_data_ff;
      end
   end

endmodule : sprt_table

`default_nettype wire

[hdl/sprt_update.sv]
// Per-command update of one entry: disable, enable, clear-all and read,
// producing the new entry, the reported entry and the status.
// Depends on sprt_pkg.
`default_nettype none

module sprt_update
   import sprt_pkg::*;
#(
   parameter int SW = 11
) (
   input  wire logic [1:0]        mode,
   input  wire logic [SW-1:0]     row,
   input  wire logic              in_range,
   input  wire logic [2*SW+1:0]   cur_entry,
   output      logic [2*SW+1:0]   nxt_entry,
   output      logic [2*SW+1:0]   res_entry,
   output      status_type        status,
   output      tbl_ctl_type       ctl
);

   // Entry layout, high to low: second valid, second row, first valid, first row.
   logic          v0;
   logic          v1;
   logic [SW-1:0] r0;
   logic [SW-1:0] r1;
   logic          hit0;
   logic          hit1;
   mode_type      op;

   assign op   = mode_type'(mode);
   assign r0   = cur_entry[SW-1:0];
   assign v0   = cur_entry[SW];
   assign r1   = cur_entry[2*SW:SW+1];
   assign v1   = cur_entry[2*SW+1];
   assign hit0 = v0 && (r0 == row);
   assign hit1 = v1 && (r1 == row);

   always_comb begin
      nxt_entry   = cur_entry;
      status      = STAT_OK;
      ctl.wr_en   = 1'b0;
      ctl.clr_all = 1'b0;
      case (op)
         MODE_DISABLE: begin
            if (in_range) begin
               // Fullness is checked ahead of the duplicate test.
               if (v0 && v1) begin
                  status = STAT_FULL;
               end else if (hit0 || hit1) begin
                  status = STAT_DUP;
               end else begin
                  ctl.wr_en = 1'b1;
                  if (v0) begin
                     nxt_entry[2*SW+1:SW+1] = {1'b1, row};
                  end else begin
                     nxt_entry[SW:0] = {1'b1, row};
                  end
               end
            end
         end
         MODE_ENABLE: begin
            if (in_range) begin
               ctl.wr_en = 1'b1;
               if (hit1) begin
                  nxt_entry[2*SW+1] = 1'b0;
               end else if (hit0) begin
                  nxt_entry[SW] = 1'b0;
               end
            end
         end
         MODE_CLEAR: begin
            ctl.clr_all = 1'b1;
         end
         default: begin
         end
      endcase

      if (op == MODE_CLEAR) begin
         res_entry = '0;
      end else if (!in_range) begin
         res_entry = '0;
         status    = STAT_RANGE;
      end else begin
         res_entry = nxt_entry;
      end
   end

endmodule : sprt_update

`default_nettype wire

[hdl/spare_row_remap_table_top.sv]
// Top level of the spare row remap table: command register, entry table,
// update logic, response register and configuration registers.
// Depends on sprt_pkg, sprt_req_if, sprt_rsp_if, sprt_table, sprt_update.
//
//   channel   direction  handshake              carries
//   req_bus   in         valid/ready            mode, row, bank, subbank, slice
//   rsp_bus   out        valid/ready            status, both slots of the entry
//   csr_*     in         csr_we, no back-press  banks_in_use, slices_in_use
//
// One command beat is taken every cycle unless the request side stalls.
// An accepted beat sits in the command register while the table memory is
// read, and its response is registered into the response register when the
// command moves on; the port holds it there until it is taken.
// Reset is synchronous; it empties both registers, marks every entry unused
// at once and loads the register defaults. The request side stalls only when
// the response register is full and not being taken.
`default_nettype none

module spare_row_remap_table_top
   import sprt_pkg::*;
#(
   parameter int ROW_BITS        = 11,
   parameter int BANKS_PER_SLICE = 4,
   parameter int SUBBANKS        = 8,
   parameter int SLICES          = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sprt_req_if.sink                   req_bus,
   sprt_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_idx,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Stored rows never need more bits than the channel carries.
   localparam int SW    = (ROW_BITS < OUT_ROW_W) ? ROW_BITS : OUT_ROW_W;
   localparam int ENT_W = 2 * (SW + 1);
   localparam int DEPTH = SLICES * BANKS_PER_SLICE * SUBBANKS;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [IDX_W-1:0] calc_idx(input logic       slice,
                                                 input logic [1:0] bank,
                                                 input logic [2:0] subbank);
      int flat;
      flat = (int'(slice) * BANKS_PER_SLICE + int'(bank)) * SUBBANKS + int'(subbank);
      return IDX_W'(flat);
   endfunction

   // Configuration registers.
   logic [2:0]       banks_ff;
   logic [1:0]       slices_ff;

   // Command register.
   logic             cmd_valid_ff;
   logic [1:0]       mode_ff;
   logic [10:0]      row_ff;
   logic [1:0]       bank_ff;
   logic [2:0]       subbank_ff;
   logic             slice_ff;

   // Response register.
   logic             rsp_valid_ff;
   logic [1:0]       status_ff;
   logic             first_valid_ff;
   logic [10:0]      first_row_ff;
   logic             second_valid_ff;
   logic [10:0]      second_row_ff;

   logic             req_take;
   logic             advance;
   logic             in_range;
   logic [ENT_W-1:0] cur_entry;
   logic [ENT_W-1:0] nxt_entry;
   logic [ENT_W-1:0] res_entry;
   status_type       upd_status;
   tbl_ctl_type      upd_ctl;
   tbl_ctl_type      tbl_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff  <= 3'd4;
         slices_ff <= 2'd1;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_BANKS:  banks_ff  <= csr_wdata;
            CSR_SLICES: slices_ff <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // The command moves on whenever the response register is free or drains.
   assign advance        = cmd_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !cmd_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         cmd_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff    <= req_bus.mode;
         row_ff     <= req_bus.row;
         bank_ff    <= req_bus.bank;
         subbank_ff <= req_bus.subbank;
         slice_ff   <= req_bus.slice;
      end
   end

   // An address is usable only inside both the built and the enabled geometry;
   // a register value of zero therefore rejects every address.
   assign in_range = ({1'b0, slice_ff} < slices_ff) && (int'(slice_ff) < SLICES)
                  && ({1'b0, bank_ff} < banks_ff) && (int'(bank_ff) < BANKS_PER_SLICE)
                  && (int'(subbank_ff) < SUBBANKS);

   // The table reads at the incoming address so the data is ready next cycle.
   sprt_table #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .ENT_W (ENT_W)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_idx    (calc_idx(req_bus.slice, req_bus.bank, req_bus.subbank)),
      .ctl       (tbl_ctl),
      .wr_data   (nxt_entry),
      .cur_entry (cur_entry)
   );

   sprt_update #(
      .SW (SW)
   ) u_update (
      .mode      (mode_ff),
      .row       (row_ff[SW-1:0]),
      .in_range  (in_range),
      .cur_entry (cur_entry),
      .nxt_entry (nxt_entry),
      .res_entry (res_entry),
      .status    (upd_status),
      .ctl       (upd_ctl)
   );

   // Table changes take effect only when the command actually completes.
   assign tbl_ctl.wr_en   = upd_ctl.wr_en && advance;
   assign tbl_ctl.clr_all = upd_ctl.clr_all && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff       <= upd_status;
         first_row_ff    <= OUT_ROW_W'(res_entry[SW-1:0]);
         first_valid_ff  <= res_entry[SW];
         second_row_ff   <= OUT_ROW_W'(res_entry[2*SW:SW+1]);
         second_valid_ff <= res_entry[2*SW+1];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.first_valid  = first_valid_ff;
   assign rsp_bus.first_row    = first_row_ff;
   assign rsp_bus.second_valid = second_valid_ff;
   assign rsp_bus.second_row   = second_row_ff;

endmodule : spare_row_remap_table_top

`default_nettype wire

[hdl/sprt_checker.sv]
// Port-level checks for the spare row remap table, bound to its top level.
// Depends on sprt_pkg and spare_row_remap_table_top.
`default_nettype none

module sprt_checker
   import sprt_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_first_valid,
   input wire logic [10:0] rsp_first_row,
   input wire logic        rsp_second_valid,
   input wire logic [10:0] rsp_second_row
);

   // No response survives reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_first_row) && $stable(rsp_second_row)
         && $stable(rsp_first_valid) && $stable(rsp_second_valid))
      else $error("stalled response changed");

   // A rejected address reports an empty entry.
   a_range_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_RANGE) |-> !rsp_first_valid
         && !rsp_second_valid && (rsp_first_row == '0) && (rsp_second_row == '0))
      else $error("out of range response carries entry data");

   a_full_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_first_valid && rsp_second_valid)
      else $error("entry full reported with a free slot");

   a_dup_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_DUP) |-> rsp_first_valid || rsp_second_valid)
      else $error("duplicate reported on an empty entry");

endmodule : sprt_checker

bind spare_row_remap_table_top sprt_checker u_sprt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_first_valid  (rsp_bus.first_valid),
   .rsp_first_row    (rsp_bus.first_row),
   .rsp_second_valid (rsp_bus.second_valid),
   .rsp_second_row   (rsp_bus.second_row)
);

`default_nettype wire

[verif/sprt_remap_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the spare row remap table: keeps its own copy of the entry table and
// registers, predicts each response beat and compares it with what the block returns.
// Depends on sprt_pkg, sprt_req_if and sprt_rsp_if.

module sprt_remap_checker
   import sprt_pkg::*;
#(
   parameter int BANKS_PER_SLICE = 4,
   parameter int SUBBANKS        = 8,
   parameter int SLICES          = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sprt_req_if                        req_mon,
   sprt_rsp_if                        rsp_mon,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_idx,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);

   localparam int DEPTH      = SLICES * BANKS_PER_SLICE * SUBBANKS;

   typedef struct packed {
      logic                 v0;
      logic [OUT_ROW_W-1:0] r0;
      logic                 v1;
      logic [OUT_ROW_W-1:0] r1;
   } slot_pair_type;

   typedef struct packed {
      status_type           status;
      logic                 first_valid;
      logic [OUT_ROW_W-1:0] first_row;
      logic                 second_valid;
      logic [OUT_ROW_W-1:0] second_row;
   } remap_beat_type;

   slot_pair_type    shadow_table [DEPTH];
   int unsigned      banks_cfg;
   int unsigned      slices_cfg;
   remap_beat_type   expected_beats [$];

   function automatic remap_beat_type apply_remap_cmd(mode_type m,
                                                      logic [OUT_ROW_W-1:0] row,
                                                      int unsigned bank, int unsigned sub,
                                                      int unsigned slice);
      remap_beat_type beat;
      slot_pair_type  ent;
      int unsigned    idx;
      beat = '0;
      if (m == MODE_CLEAR) begin
         foreach (shadow_table[i]) shadow_table[i] = '0;
         return beat;
      end
      if (slice >= slices_cfg || slice >= SLICES || bank >= banks_cfg ||
          bank >= BANKS_PER_SLICE || sub >= SUBBANKS) begin
         beat.status = STAT_RANGE;
         return beat;
      end
      idx = (slice * BANKS_PER_SLICE + bank) * SUBBANKS + sub;
      ent = shadow_table[idx];
      beat.status = STAT_OK;
      if (m == MODE_DISABLE) begin
         // Fullness wins over the duplicate test.
         if (ent.v0 && ent.v1) begin
            beat.status = STAT_FULL;
         end else if ((ent.v0 && ent.r0 == row) || (ent.v1 && ent.r1 == row)) begin
            beat.status = STAT_DUP;
         end else if (ent.v0) begin
            ent.r1 = row;
            ent.v1 = 1'b1;
         end else begin
            ent.r0 = row;
            ent.v0 = 1'b1;
         end
      end else if (m == MODE_ENABLE) begin
         // Only the valid bit drops; the stale row number is still reported.
         if (ent.v1 && ent.r1 == row) begin
            ent.v1 = 1'b0;
         end else if (ent.v0 && ent.r0 == row) begin
            ent.v0 = 1'b0;
         end
      end
      shadow_table[idx] = ent;
      beat.first_valid  = ent.v0;
      beat.first_row    = ent.r0;
      beat.second_valid = ent.v1;
      beat.second_row   = ent.r1;
      return beat;
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   always @(posedge clock) begin
      remap_beat_type want;
      if (reset) begin
         foreach (shadow_table[i]) shadow_table[i] = '0;
         banks_cfg  = 4;
         slices_cfg = 1;
         expected_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_idx))
               CSR_BANKS:  banks_cfg  = 32'(csr_wdata & 3'd7);
               CSR_SLICES: slices_cfg = 32'(csr_wdata[1:0]);
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: response beat with none expected, actual status %0d",
                        $time, rsp_mon.status);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("status", want.status, rsp_mon.status);
               check_field("first_valid", want.first_valid, rsp_mon.first_valid);
               check_field("first_row", want.first_row, rsp_mon.first_row);
               check_field("second_valid", want.second_valid, rsp_mon.second_valid);
               check_field("second_row", want.second_row, rsp_mon.second_row);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_beats.push_back(apply_remap_cmd(mode_type'(req_mon.mode), req_mon.row,
                                                     req_mon.bank, req_mon.subbank,
                                                     req_mon.slice));
         end
      end
      outstanding <= expected_beats.size();
   end

endmodule : sprt_remap_checker

[verif/tb.sv]
`timescale 1ns / 1ps
// Top of the spare row remap table testbench: clock, reset, command stimulus, register
// phases, response back-pressure, watchdog and verdict. Depends on sprt_pkg, both channel
// interfaces, spare_row_remap_table_top and sprt_remap_checker.

module tb;
   import sprt_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   // A taken beat passes the command and response registers before it answers.
   localparam int SETTLE_CYCLES  = 4;
   localparam int NUM_PHASES     = 8;
   localparam int HOT_ADDRS      = 4;
   localparam int HOT_ROWS       = 6;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    outstanding;
   int                    idle_cycles;

   // Idle bursts on the command side and stalls on the response side are switched off
   // together for the final phase so that the tail runs at full rate.
   bit                    gaps_on;
   bit                    rsp_stalls_on;

   // Per-phase hot set: a few addresses and rows that most random beats reuse, so that
   // entries fill up, duplicates get refused and enables actually find their row.
   logic [1:0]            hot_bank  [HOT_ADDRS];
   logic [2:0]            hot_sub   [HOT_ADDRS];
   logic                  hot_slice [HOT_ADDRS];
   logic [OUT_ROW_W-1:0]  hot_row   [HOT_ROWS];

   // Register settings per phase; the extremes and masked write data are in the list.
   int                    phase_banks  [NUM_PHASES] = '{4, 1, 2, 0, 3, 7, 5, 4};
   int                    phase_slices [NUM_PHASES] = '{2, 1, 2, 2, 0, 3, 5, 2};

   sprt_req_if req_bus ();
   sprt_rsp_if rsp_bus ();

   always #6 clock = ~clock;

   spare_row_remap_table_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   sprt_remap_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_idx        (csr_idx),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Offer one command beat at a falling edge and hold it until a rising edge sees ready.
   // Valid stays high into the next call unless an idle burst is drawn here.
   task automatic send_cmd(input mode_type m, input logic [OUT_ROW_W-1:0] row,
                           input logic [1:0] bank, input logic [2:0] sub, input logic slice);
      int gap;
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= m;
      req_bus.row     <= row;
      req_bus.bank    <= bank;
      req_bus.subbank <= sub;
      req_bus.slice   <= slice;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Register writes take one cycle each and are only issued while the block is idle.
   task automatic write_csr(input csr_idx_type idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Drop valid, wait for every outstanding response, then let the pipeline settle.
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_hot_set();
      for (int i = 0; i < HOT_ADDRS; i++) begin
         hot_bank[i]  = 2'($urandom_range(0, 3));
         hot_sub[i]   = 3'($urandom_range(0, 7));
         hot_slice[i] = 1'($urandom_range(0, 1));
      end
      // The row extremes always sit in the pool.
      hot_row[0] = '0;
      hot_row[1] = '1;
      for (int i = 2; i < HOT_ROWS; i++) hot_row[i] = OUT_ROW_W'($urandom_range(0, 2047));
   endtask

   // Mostly disables and enables on the hot set, with reads to observe entries, a few
   // clears, and some fully random beats that scatter across the whole table.
   task automatic send_random_cmd();
      int                   pick;
      int                   a;
      mode_type             m;
      logic [OUT_ROW_W-1:0] row;
      logic [1:0]           bank;
      logic [2:0]           sub;
      logic                 slice;
      pick = $urandom_range(0, 99);
      if (pick < 42)      m = MODE_DISABLE;
      else if (pick < 72) m = MODE_ENABLE;
      else if (pick < 97) m = MODE_READ;
      else                m = MODE_CLEAR;
      if ($urandom_range(0, 99) < 75) begin
         a     = $urandom_range(0, HOT_ADDRS - 1);
         bank  = hot_bank[a];
         sub   = hot_sub[a];
         slice = hot_slice[a];
      end else begin
         bank  = 2'($urandom_range(0, 3));
         sub   = 3'($urandom_range(0, 7));
         slice = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 70) row = hot_row[$urandom_range(0, HOT_ROWS - 1)];
      else                            row = OUT_ROW_W'($urandom_range(0, 2047));
      send_cmd(m, row, bank, sub, slice);
   endtask

   // Response back-pressure: ready stays high for a random stretch, then may drop for a
   // random burst. Every change lands on a falling edge.
   initial begin : rsp_ready_gen
      int n;
      rsp_bus.ready = 1'b1;
      forever begin
         n = $urandom_range(1, 12);
         repeat (n) @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int n_items;
      idle_cycles     = 0;
      gaps_on         = 1'b1;
      rsp_stalls_on   = 1'b1;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_idx         = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.mode    = MODE_READ;
      req_bus.row     = '0;
      req_bus.bank    = '0;
      req_bus.subbank = '0;
      req_bus.slice   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, run under the reset register values (four banks, one slice).
      // One entry at the top corner is walked through fill, duplicate, full and the
      // enable cases; then out-of-range addresses and a clear with an odd address.
      send_cmd(MODE_READ,    11'd0,    2'd0, 3'd0, 1'b0);
      send_cmd(MODE_DISABLE, 11'd2047, 2'd3, 3'd7, 1'b0);
      send_cmd(MODE_DISABLE, 11'd2047, 2'd3, 3'd7, 1'b0);
      send_cmd(MODE_DISABLE, 11'd0,    2'd3, 3'd7, 1'b0);
      send_cmd(MODE_DISABLE, 11'd1365, 2'd3, 3'd7, 1'b0);
      send_cmd(MODE_READ,    11'd0,    2'd3, 3'd7, 1'b0);
      send_cmd(MODE_ENABLE,  11'd2047, 2'd3, 3'd7, 1'b0);
      send_cmd(MODE_ENABLE,  11'd2047, 2'd3, 3'd7, 1'b0);
      send_cmd(MODE_DISABLE, 11'd682,  2'd3, 3'd7, 1'b0);
      send_cmd(MODE_ENABLE,  11'd0,    2'd3, 3'd7, 1'b0);
      send_cmd(MODE_ENABLE,  11'd682,  2'd3, 3'd7, 1'b0);
      send_cmd(MODE_DISABLE, 11'd682,  2'd3, 3'd7, 1'b1);
      send_cmd(MODE_READ,    11'd0,    2'd3, 3'd7, 1'b1);
      send_cmd(MODE_ENABLE,  11'd682,  2'd0, 3'd0, 1'b1);
      send_cmd(MODE_DISABLE, 11'd5,    2'd0, 3'd0, 1'b0);
      send_cmd(MODE_CLEAR,   11'd2047, 2'd3, 3'd7, 1'b1);
      send_cmd(MODE_READ,    11'd0,    2'd0, 3'd0, 1'b0);
      send_cmd(MODE_READ,    11'd0,    2'd3, 3'd7, 1'b0);

      // Random phases: registers change only once the block has gone quiet. Settings
      // that shut every address out get shorter phases since they only exercise refusal.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_block();
         write_csr(CSR_BANKS, phase_banks[p]);
         write_csr(CSR_SLICES, phase_slices[p]);
         pick_hot_set();
         gaps_on       = (p != NUM_PHASES - 1);
         rsp_stalls_on = gaps_on;
         n_items = (phase_banks[p] == 0 || (phase_slices[p] & 3) == 0) ? 30 : 90;
         repeat (n_items) send_random_cmd();
      end

      drain_block();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule : tb
